[rtl/core/acfr_pkg.sv]
// Package for the arc center block: widths, status codes and pipeline types.
// Used by every module in rtl/core; depends on nothing.
package acfr_pkg;

	// Width of one position or radius on the bus.
	localparam int POS_BITS = 24;

	// Axis difference and center offset width.
	localparam int XW = POS_BITS + 1;
	// Square of a difference, sum of two squares, and the signed q term.
	localparam int SQW = 2 * POS_BITS + 1;
	localparam int RW = 2 * POS_BITS + 2;
	localparam int QQW = 2 * POS_BITS + 3;
	// Square root result and the root cell remainder.
	localparam int RT = RW / 2;
	localparam int RMW = POS_BITS + 4;
	// Divider: dividend, quotient and remainder widths.
	localparam int DW = RT + XW;
	localparam int QW = POS_BITS + 2;
	localparam int DRW = RT;
	// Final offset arithmetic width.
	localparam int FW = POS_BITS + 4;

	// Bus widths, padded to whole bytes.
	localparam int IN_TDATA_W = ((5 * POS_BITS + 1 + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((2 * XW + 7) / 8) * 8;

	// Registers from the third stage to the end of the divider chains (root, product, divider).
	localparam int CHAIN_LEN = RT + 1 + QW;

	typedef enum logic [1:0] {
		ST_OK           = 2'd0,
		ST_ZERO_DISP    = 2'd1,
		ST_RADIUS_SMALL = 2'd2
	} status_t;

	// Per-item data that rides alongside the root and divider chains.
	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic                 neg;
		status_t              st;
	} side_t;

	// One finished result.
	typedef struct packed {
		logic [XW-1:0] off_a;
		logic [XW-1:0] off_b;
		status_t       st;
	} res_t;

endpackage

[rtl/core/arc_center_from_radius.sv]
// Top level of the arc center block: input stages, root and divider cell chains,
// offset stage and output skid buffer. Depends on acfr_pkg, acfr_sqrt_cell, acfr_div_cell.

// The block takes one beat per clock while the skid entry is empty and returns one result
// beat for each, in order. A beat passes through three input stages, a chain of 25 square
// root cells (one root bit each), a product stage, a chain of 26 divider cells (one quotient
// bit each) and the output register.
// A two-entry output buffer lets the input keep flowing while the output stalls, until a result
// has to go into the skid entry; while the buffer is full the whole pipeline holds.
module arc_center_from_radius (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// target_a, target_b, current_a, current_b, radius, clockwise, zero pad
	input  logic [acfr_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// center_off_a, center_off_b, zero pad
	output logic [acfr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	// status
	output logic [1:0]                          m_axis_tuser
);
	import acfr_pkg::*;

	localparam int P = POS_BITS;

	logic en;
	logic skid_vld_q;
	logic out_vld_q;
	res_t out_q;
	res_t skid_q;

	assign en = !skid_vld_q;
	assign s_axis_tready = en;

	// Stage 1: axis differences.
	logic                 v_s1;
	logic signed [XW-1:0] x_s1, y_s1;
	logic signed [P-1:0]  r_s1;
	logic                 cw_s1;
	logic [P-1:0] tgt_a, tgt_b, cur_a, cur_b;

	assign tgt_a = s_axis_tdata[P-1:0];
	assign tgt_b = s_axis_tdata[2*P-1:P];
	assign cur_a = s_axis_tdata[3*P-1:2*P];
	assign cur_b = s_axis_tdata[4*P-1:3*P];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1  <= $signed({tgt_a[P-1], tgt_a}) - $signed({cur_a[P-1], cur_a});
			y_s1  <= $signed({tgt_b[P-1], tgt_b}) - $signed({cur_b[P-1], cur_b});
			r_s1  <= $signed(s_axis_tdata[5*P-1:4*P]);
			cw_s1 <= s_axis_tdata[5*P];
		end
	end

	// Stage 2: squares.
	logic                   v_s2;
	logic [SQW-1:0]         xx_s2, yy_s2;
	logic [2*P-1:0]         rr_s2;
	logic signed [XW-1:0]   x_s2, y_s2;
	logic                   neg_s2, zero_s2;
	logic signed [2*XW-1:0] xsq, ysq;
	logic signed [2*P-1:0]  rsq;

	assign xsq = x_s1 * x_s1;
	assign ysq = y_s1 * y_s1;
	assign rsq = r_s1 * r_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xx_s2   <= xsq[SQW-1:0];
			yy_s2   <= ysq[SQW-1:0];
			rr_s2   <= rsq;
			x_s2    <= x_s1;
			y_s2    <= y_s1;
			neg_s2  <= cw_s1 ^ r_s1[P-1];
			zero_s2 <= (x_s1 == '0) && (y_s1 == '0);
		end
	end

	// Stage 3: the term under the root and the squared chord; error status.
	logic                  v_s3;
	logic signed [QQW-1:0] q_s3;
	logic [RW-1:0]         dd_s3;
	side_t                 side_s3;
	logic signed [QQW-1:0] q_c;

	assign q_c = $signed({1'b0, rr_s2, 2'b00}) - $signed({2'b00, xx_s2})
		- $signed({2'b00, yy_s2});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s3        <= q_c;
			dd_s3       <= {1'b0, xx_s2} + {1'b0, yy_s2};
			side_s3.x   <= x_s2;
			side_s3.y   <= y_s2;
			side_s3.neg <= neg_s2;
			if (zero_s2) begin
				side_s3.st <= ST_ZERO_DISP;
			end else if (q_c[QQW-1]) begin
				side_s3.st <= ST_RADIUS_SMALL;
			end else begin
				side_s3.st <= ST_OK;
			end
		end
	end

	// Sideband and valid bits that travel with the cell chains.
	logic  vld_c [CHAIN_LEN+1];
	side_t sd_c  [CHAIN_LEN+1];

	assign vld_c[0] = v_s3;
	assign sd_c[0]  = side_s3;

	for (genvar k = 1; k <= CHAIN_LEN; k++) begin : g_side
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_c[k] <= 1'b0;
			end else if (en) begin
				vld_c[k] <= vld_c[k-1];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				sd_c[k] <= sd_c[k-1];
			end
		end
	end

	// Two root chains: h from q, d from the squared chord.
	logic [RMW-1:0] hrem [RT+1];
	logic [RW-1:0]  hrad [RT+1];
	logic [RT-1:0]  hroot[RT+1];
	logic [RMW-1:0] drem [RT+1];
	logic [RW-1:0]  drad [RT+1];
	logic [RT-1:0]  droot[RT+1];

	assign hrem[0]  = '0;
	assign hrad[0]  = q_s3[RW-1:0];
	assign hroot[0] = '0;
	assign drem[0]  = '0;
	assign drad[0]  = dd_s3;
	assign droot[0] = '0;

	for (genvar k = 0; k < RT; k++) begin : g_root
		acfr_sqrt_cell u_h (
			.clk   (clk),
			.en    (en),
			.rem_i (hrem[k]),
			.rad_i (hrad[k]),
			.root_i(hroot[k]),
			.rem_q (hrem[k+1]),
			.rad_q (hrad[k+1]),
			.root_q(hroot[k+1])
		);
		acfr_sqrt_cell u_d (
			.clk   (clk),
			.en    (en),
			.rem_i (drem[k]),
			.rad_i (drad[k]),
			.root_i(droot[k]),
			.rem_q (drem[k+1]),
			.rad_q (drad[k+1]),
			.root_q(droot[k+1])
		);
	end

	// Product stage: h times the axis magnitudes, divisor kept at least one.
	logic [DW-1:0]  na_sm, nb_sm;
	logic [DRW-1:0] dv_sm;
	logic [XW-1:0]  xmag, ymag;
	side_t          sd_r;

	assign sd_r = sd_c[RT];
	assign xmag = sd_r.x[XW-1] ? XW'(-sd_r.x) : XW'(sd_r.x);
	assign ymag = sd_r.y[XW-1] ? XW'(-sd_r.y) : XW'(sd_r.y);

	always_ff @(posedge clk) begin
		if (en) begin
			na_sm <= hroot[RT] * ymag;
			nb_sm <= hroot[RT] * xmag;
			dv_sm <= (droot[RT] == '0) ? DRW'(1) : droot[RT];
		end
	end

	// Two divider chains for the magnitudes of pa and pb.
	logic [DRW-1:0] adv [QW+1];
	logic [DRW-1:0] arem[QW+1];
	logic [QW-1:0]  alow[QW+1];
	logic [QW-1:0]  aquo[QW+1];
	logic [DRW-1:0] bdv [QW+1];
	logic [DRW-1:0] brem[QW+1];
	logic [QW-1:0]  blow[QW+1];
	logic [QW-1:0]  bquo[QW+1];

	assign adv[0]  = dv_sm;
	assign arem[0] = DRW'(na_sm[DW-1:QW]);
	assign alow[0] = na_sm[QW-1:0];
	assign aquo[0] = '0;
	assign bdv[0]  = dv_sm;
	assign brem[0] = DRW'(nb_sm[DW-1:QW]);
	assign blow[0] = nb_sm[QW-1:0];
	assign bquo[0] = '0;

	for (genvar k = 0; k < QW; k++) begin : g_div
		acfr_div_cell u_a (
			.clk  (clk),
			.en   (en),
			.dvs_i(adv[k]),
			.rem_i(arem[k]),
			.low_i(alow[k]),
			.quo_i(aquo[k]),
			.dvs_q(adv[k+1]),
			.rem_q(arem[k+1]),
			.low_q(alow[k+1]),
			.quo_q(aquo[k+1])
		);
		acfr_div_cell u_b (
			.clk  (clk),
			.en   (en),
			.dvs_i(bdv[k]),
			.rem_i(brem[k]),
			.low_i(blow[k]),
			.quo_i(bquo[k]),
			.dvs_q(bdv[k+1]),
			.rem_q(brem[k+1]),
			.low_q(blow[k+1]),
			.quo_q(bquo[k+1])
		);
	end

	// Offset stage: sign the quotients, halve toward zero and saturate; zero offsets on an error status.
	side_t                sd_f;
	logic                 fin_vld;
	logic signed [FW-1:0] pa, pb, xe, ye, va, vb, ha, hb;
	logic signed [FW-1:0] hi, lo;
	res_t                 fin;

	assign sd_f    = sd_c[CHAIN_LEN];
	assign fin_vld = vld_c[CHAIN_LEN];
	assign hi      = $signed({{(FW-XW+1){1'b0}}, {(XW-1){1'b1}}});
	assign lo      = ~hi;

	always_comb begin
		pa = $signed(FW'(aquo[QW]));
		pb = $signed(FW'(bquo[QW]));
		if (sd_f.neg ^ sd_f.y[XW-1]) begin
			pa = -pa;
		end
		if (sd_f.neg ^ sd_f.x[XW-1]) begin
			pb = -pb;
		end
		xe = FW'(sd_f.x);
		ye = FW'(sd_f.y);
		va = xe - pa;
		vb = ye + pb;
		ha = (va + $signed(FW'(va[FW-1]))) >>> 1;
		hb = (vb + $signed(FW'(vb[FW-1]))) >>> 1;
		fin.st = sd_f.st;
		if (sd_f.st != ST_OK) begin
			fin.off_a = '0;
			fin.off_b = '0;
		end else begin
			fin.off_a = (ha > hi) ? hi[XW-1:0] : ((ha < lo) ? lo[XW-1:0] : ha[XW-1:0]);
			fin.off_b = (hb > hi) ? hi[XW-1:0] : ((hb < lo) ? lo[XW-1:0] : hb[XW-1:0]);
		end
	end

	// Output register with a skid entry behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (m_axis_tready) begin
				skid_vld_q <= 1'b0;
			end
		end else if (fin_vld) begin
			if (out_vld_q && !m_axis_tready) begin
				skid_vld_q <= 1'b1;
			end else begin
				out_vld_q <= 1'b1;
			end
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (m_axis_tready) begin
				out_q <= skid_q;
			end
		end else if (fin_vld) begin
			if (out_vld_q && !m_axis_tready) begin
				skid_q <= fin;
			end else begin
				out_q <= fin;
			end
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = OUT_TDATA_W'({out_q.off_b, out_q.off_a});
	assign m_axis_tuser  = out_q.st;

endmodule

[rtl/core/acfr_sqrt_cell.sv]
// One cell of the pipelined square root chain: settles one root bit per cycle while en is high.
// Depends on acfr_pkg.
module acfr_sqrt_cell (
	input  logic                    clk,
	input  logic                    en,
	input  logic [acfr_pkg::RMW-1:0] rem_i,
	input  logic [acfr_pkg::RW-1:0]  rad_i,
	input  logic [acfr_pkg::RT-1:0]  root_i,
	output logic [acfr_pkg::RMW-1:0] rem_q,
	output logic [acfr_pkg::RW-1:0]  rad_q,
	output logic [acfr_pkg::RT-1:0]  root_q
);
	import acfr_pkg::*;

	logic [RMW-1:0] r2;
	logic [RMW-1:0] trial;
	logic           ge;

	// Bring down the next two radicand bits and try the next root bit.
	always_comb begin
		r2    = {rem_i[RMW-3:0], rad_i[RW-1:RW-2]};
		trial = {{(RMW-RT-2){1'b0}}, root_i, 2'b01};
		ge    = (r2 >= trial);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= ge ? (r2 - trial) : r2;
			rad_q  <= {rad_i[RW-3:0], 2'b00};
			root_q <= {root_i[RT-2:0], ge};
		end
	end

endmodule

[rtl/core/acfr_div_cell.sv]
// One cell of the pipelined restoring divider: settles one quotient bit per cycle while en is high.
// Depends on acfr_pkg.
module acfr_div_cell (
	input  logic                    clk,
	input  logic                    en,
	input  logic [acfr_pkg::DRW-1:0] dvs_i,
	input  logic [acfr_pkg::DRW-1:0] rem_i,
	input  logic [acfr_pkg::QW-1:0]  low_i,
	input  logic [acfr_pkg::QW-1:0]  quo_i,
	output logic [acfr_pkg::DRW-1:0] dvs_q,
	output logic [acfr_pkg::DRW-1:0] rem_q,
	output logic [acfr_pkg::QW-1:0]  low_q,
	output logic [acfr_pkg::QW-1:0]  quo_q
);
	import acfr_pkg::*;

	logic [DRW:0] r2;
	logic [DRW:0] dext;
	logic         ge;
	logic [DRW:0] diff;

	// Shift in the next dividend bit and subtract the divisor if it fits.
	always_comb begin
		r2   = {rem_i, low_i[QW-1]};
		dext = {1'b0, dvs_i};
		ge   = (r2 >= dext);
		diff = r2 - dext;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dvs_q <= dvs_i;
			rem_q <= ge ? diff[DRW-1:0] : r2[DRW-1:0];
			low_q <= {low_i[QW-2:0], 1'b0};
			quo_q <= {quo_i[QW-2:0], ge};
		end
	end

endmodule

[rtl/core/acfr_checker.sv]
// Port-level checker for the arc center block and its bind to the top level.
// Depends on acfr_pkg and arc_center_from_radius.
module acfr_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_axis_tvalid,
	input logic                              s_axis_tready,
	input logic [acfr_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	input logic                              m_axis_tvalid,
	input logic                              m_axis_tready,
	input logic [acfr_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	input logic [1:0]                        m_axis_tuser
);
	import acfr_pkg::*;

	// A held result beat keeps its contents.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
		else $error("result beat changed while stalled");

	// Only the three defined status codes leave the block.
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser == ST_OK) || (m_axis_tuser == ST_ZERO_DISP)
			|| (m_axis_tuser == ST_RADIUS_SMALL))
		else $error("undefined status code");

	// Error results carry zero offsets.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != ST_OK) |-> m_axis_tdata[2*XW-1:0] == '0)
		else $error("nonzero offset on an error result");

	// Input backpressure only appears while a result is waiting.
	a_bp_out: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with no result pending");

	// The buffer stays full until the output side takes a beat.
	a_bp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready && !m_axis_tready |=> !s_axis_tready)
		else $error("input released without output progress");

endmodule

bind arc_center_from_radius acfr_checker u_acfr_checker (.*);
